>>> sv/vwma_pkg.sv
// vwma_pkg: types, constants and helper functions for the voxel weighted mean accumulator
// used by voxel_weighted_mean_accumulator, which instantiates vwma_ram, and by the bench; no dependencies

package vwma_pkg;

    localparam int VOXEL_COUNT = 65536;
    localparam int ADDR_W      = $clog2(VOXEL_COUNT);
    localparam int WSUM_W      = 32;
    localparam int TOTAL_W     = 32;
    localparam int DEN_W       = WSUM_W + 1;
    localparam int PROD_W      = WSUM_W + 16;
    localparam int SUM_W       = PROD_W + 2;
    localparam int MAG_W       = SUM_W - 1;
    // quotient of 2*|num|/den, one bit per step; the extra low bit carries rounding
    localparam int QB_W        = 17;
    localparam int QCNT_W      = $clog2(QB_W + 1);

    localparam logic [QB_W-1:0]    Q_POS_MAX = QB_W'(32767);
    localparam logic [QB_W-1:0]    Q_NEG_MAX = QB_W'(32768);
    localparam logic [15:0]        MEAN_POS_SAT = 16'h7FFF;
    localparam logic [15:0]        MEAN_NEG_SAT = 16'h8000;
    localparam logic [WSUM_W-1:0]  WSUM_MAX  = {WSUM_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef enum logic [1:0] {
        OP_ACC   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                operation;
        logic [15:0]        voxel_addr;
        logic [15:0]        sample_weight;
        logic signed [15:0] sample_value;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0]   mean_value;
        logic [TOTAL_W-1:0]   weight_total;
        logic                 has_data;
    } result_t;

    typedef struct packed {
        logic                 filled;
        logic [WSUM_W-1:0]    weight;
        logic signed [15:0]   mean;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLR,
        S_RD,
        S_LOAD,
        S_MUL_A,
        S_MUL_B,
        S_SUM,
        S_ABS,
        S_DIV,
        S_FIN
    } state_t;

    function automatic logic [15:0] abs16(input logic signed [15:0] x);
        logic [15:0] r;
        r = x[15] ? 16'(-x) : 16'(x);
        return r;
    endfunction

    function automatic logic [WSUM_W-1:0] sat_wsum(input logic [DEN_W-1:0] s);
        logic [WSUM_W-1:0] r;
        r = s[DEN_W-1] ? WSUM_MAX : s[WSUM_W-1:0];
        return r;
    endfunction

    function automatic logic [TOTAL_W-1:0] sat_total(input logic [WSUM_W-1:0] s);
        logic [WSUM_W+TOTAL_W-1:0] ext;
        logic [TOTAL_W-1:0]        r;
        ext = (WSUM_W + TOTAL_W)'(s);
        r   = (ext > (WSUM_W + TOTAL_W)'(TOTAL_MAX)) ? TOTAL_MAX : ext[TOTAL_W-1:0];
        return r;
    endfunction

endpackage

>>> sv/vwma_ram.sv
// vwma_ram: generic simple dual port ram, one write and one registered read port
// no package dependency

module vwma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/voxel_weighted_mean_accumulator.sv
// voxel_weighted_mean_accumulator: per-voxel running weighted mean and weight sum
// depends on vwma_pkg and vwma_ram
// accumulate into a filled voxel: read, load, two multiplier passes, sum, absolute value,
// 17 restoring divider steps and the final write; first hit or read ends after the load;
// unused code or bad index answers from idle; one item at a time, busy high until the
// result beat; clear and reset sweep all VOXEL_COUNT flags with busy high; no result stall

module voxel_weighted_mean_accumulator (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  vwma_pkg::cmd_t   cmd,
    output logic             done,
    output vwma_pkg::result_t result
);

    vwma_pkg::state_t state_reg, state_next;

    logic [vwma_pkg::ADDR_W-1:0] idx_reg, idx_next;
    logic [vwma_pkg::ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    vwma_pkg::op_t               op_reg, op_next;
    logic [15:0]                 w_reg, w_next;
    logic signed [15:0]          v_reg, v_next;
    logic signed [15:0]          m_reg, m_next;
    logic [vwma_pkg::WSUM_W-1:0] wsum_reg, wsum_next;
    logic [vwma_pkg::DEN_W-1:0]  den_reg, den_next;
    logic [vwma_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [vwma_pkg::SUM_W-1:0] acc_reg, acc_next;
    logic                        neg_reg, neg_next;
    logic [vwma_pkg::DEN_W-1:0]  rem_reg, rem_next;
    logic [vwma_pkg::QB_W-1:0]   num_reg, num_next;
    logic [vwma_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    vwma_pkg::result_t           result_reg, result_next;
    logic                        done_reg, done_next;

    logic                        ram_we;
    logic [vwma_pkg::ADDR_W-1:0] ram_waddr;
    vwma_pkg::entry_t            ram_wdata;
    logic [vwma_pkg::ENTRY_W-1:0] ram_rdata;
    vwma_pkg::entry_t            rd_entry;

    logic                        accept;
    logic                        in_range;
    logic                        last_clr;
    logic                        div_last;

    logic [vwma_pkg::WSUM_W-1:0] mul_a;
    logic [15:0]                 mul_b;
    logic [vwma_pkg::PROD_W-1:0] mul_p;
    logic signed [vwma_pkg::SUM_W-1:0] prod_s;
    logic [vwma_pkg::MAG_W-1:0]  acc_mag;
    logic [vwma_pkg::DEN_W:0]    div_t;
    logic [vwma_pkg::DEN_W:0]    div_sub;
    logic                        div_ge;
    logic [vwma_pkg::QB_W:0]     q_round;
    logic [vwma_pkg::QB_W-1:0]   q;
    logic signed [15:0]          mean_new;
    logic [vwma_pkg::WSUM_W-1:0] wsum_new;

    vwma_ram #(
        .WIDTH (vwma_pkg::ENTRY_W),
        .DEPTH (vwma_pkg::VOXEL_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_entry = vwma_pkg::entry_t'(ram_rdata);
    assign busy     = (state_reg != vwma_pkg::S_IDLE);
    assign accept   = start && !busy;
    assign in_range = (32'(cmd.voxel_addr) < 32'(vwma_pkg::VOXEL_COUNT));
    assign last_clr = (clr_cnt_reg == vwma_pkg::ADDR_W'(vwma_pkg::VOXEL_COUNT - 1));
    assign div_last = (cnt_reg == vwma_pkg::QCNT_W'(vwma_pkg::QB_W - 1));

    // shared multiplier: W*|m| first, then w*|v|
    always_comb
    begin
        if (state_reg == vwma_pkg::S_MUL_A)
        begin
            mul_a = wsum_reg;
            mul_b = vwma_pkg::abs16(m_reg);
        end
        else
        begin
            mul_a = vwma_pkg::WSUM_W'(w_reg);
            mul_b = vwma_pkg::abs16(v_reg);
        end
    end

    assign mul_p   = vwma_pkg::PROD_W'(mul_a) * vwma_pkg::PROD_W'(mul_b);
    assign prod_s  = signed'({2'b00, prod_reg});
    assign acc_mag = acc_reg[vwma_pkg::SUM_W-1]
                   ? vwma_pkg::MAG_W'(-acc_reg) : vwma_pkg::MAG_W'(acc_reg);

    // restoring divider step
    assign div_t   = {rem_reg, num_reg[vwma_pkg::QB_W-1]};
    assign div_ge  = (div_t >= {1'b0, den_reg});
    assign div_sub = div_t - {1'b0, den_reg};

    // floor(2*mag/den) plus one, halved, gives round half away from zero on the magnitude
    assign q_round = (vwma_pkg::QB_W + 1)'(num_reg) + 1'b1;
    assign q       = q_round[vwma_pkg::QB_W:1];

    always_comb
    begin
        if (den_reg == '0)
        begin
            mean_new = m_reg;
        end
        else if (neg_reg)
        begin
            mean_new = (q > vwma_pkg::Q_NEG_MAX) ? signed'(vwma_pkg::MEAN_NEG_SAT)
                                                 : signed'(16'(-q[15:0]));
        end
        else
        begin
            mean_new = (q > vwma_pkg::Q_POS_MAX) ? signed'(vwma_pkg::MEAN_POS_SAT)
                                                 : signed'(q[15:0]);
        end
    end

    assign wsum_new = vwma_pkg::sat_wsum(den_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vwma_pkg::S_INIT:
            begin
                if (last_clr)
                begin
                    state_next = vwma_pkg::S_IDLE;
                end
            end
            vwma_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.operation == vwma_pkg::OP_CLEAR)
                    begin
                        state_next = vwma_pkg::S_CLR;
                    end
                    else if (cmd.operation != vwma_pkg::OP_NOP && in_range)
                    begin
                        state_next = vwma_pkg::S_RD;
                    end
                end
            end
            vwma_pkg::S_CLR:
            begin
                if (last_clr)
                begin
                    state_next = vwma_pkg::S_IDLE;
                end
            end
            vwma_pkg::S_RD:
            begin
                state_next = vwma_pkg::S_LOAD;
            end
            vwma_pkg::S_LOAD:
            begin
                if (op_reg == vwma_pkg::OP_ACC && rd_entry.filled)
                begin
                    state_next = vwma_pkg::S_MUL_A;
                end
                else
                begin
                    state_next = vwma_pkg::S_IDLE;
                end
            end
            vwma_pkg::S_MUL_A: state_next = vwma_pkg::S_MUL_B;
            vwma_pkg::S_MUL_B: state_next = vwma_pkg::S_SUM;
            vwma_pkg::S_SUM:   state_next = vwma_pkg::S_ABS;
            vwma_pkg::S_ABS:   state_next = vwma_pkg::S_DIV;
            vwma_pkg::S_DIV:
            begin
                if (div_last)
                begin
                    state_next = vwma_pkg::S_FIN;
                end
            end
            vwma_pkg::S_FIN:   state_next = vwma_pkg::S_IDLE;
            default:           state_next = vwma_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        idx_next     = idx_reg;
        clr_cnt_next = clr_cnt_reg;
        op_next      = op_reg;
        w_next       = w_reg;
        v_next       = v_reg;
        m_next       = m_reg;
        wsum_next    = wsum_reg;
        den_next     = den_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        rem_next     = rem_reg;
        num_next     = num_reg;
        cnt_next     = cnt_reg;
        result_next  = result_reg;
        done_next    = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg;
        ram_wdata    = '0;

        unique case (state_reg)
            vwma_pkg::S_INIT:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            vwma_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    idx_next     = vwma_pkg::ADDR_W'(cmd.voxel_addr);
                    op_next      = cmd.operation;
                    w_next       = cmd.sample_weight;
                    v_next       = cmd.sample_value;
                    clr_cnt_next = '0;
                    if (cmd.operation == vwma_pkg::OP_NOP || !in_range)
                    begin
                        result_next = '0;
                        done_next   = 1'b1;
                    end
                end
            end
            vwma_pkg::S_CLR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (last_clr)
                begin
                    result_next = '0;
                    done_next   = 1'b1;
                end
            end
            vwma_pkg::S_RD:
            begin
            end
            vwma_pkg::S_LOAD:
            begin
                if (op_reg == vwma_pkg::OP_ACC && !rd_entry.filled)
                begin
                    ram_we                   = 1'b1;
                    ram_wdata.filled         = 1'b1;
                    ram_wdata.weight         = vwma_pkg::WSUM_W'(w_reg);
                    ram_wdata.mean           = v_reg;
                    result_next.mean_value   = v_reg;
                    result_next.weight_total = vwma_pkg::sat_total(vwma_pkg::WSUM_W'(w_reg));
                    result_next.has_data     = 1'b1;
                    done_next                = 1'b1;
                end
                else if (op_reg == vwma_pkg::OP_ACC)
                begin
                    wsum_next = rd_entry.weight;
                    m_next    = rd_entry.mean;
                    den_next  = vwma_pkg::DEN_W'(rd_entry.weight) + vwma_pkg::DEN_W'(w_reg);
                end
                else if (rd_entry.filled)
                begin
                    result_next.mean_value   = rd_entry.mean;
                    result_next.weight_total = vwma_pkg::sat_total(rd_entry.weight);
                    result_next.has_data     = 1'b1;
                    done_next                = 1'b1;
                end
                else
                begin
                    result_next = '0;
                    done_next   = 1'b1;
                end
            end
            vwma_pkg::S_MUL_A:
            begin
                prod_next = mul_p;
            end
            vwma_pkg::S_MUL_B:
            begin
                acc_next  = m_reg[15] ? -prod_s : prod_s;
                prod_next = mul_p;
            end
            vwma_pkg::S_SUM:
            begin
                acc_next = acc_reg + (v_reg[15] ? -prod_s : prod_s);
            end
            vwma_pkg::S_ABS:
            begin
                neg_next = acc_reg[vwma_pkg::SUM_W-1];
                rem_next = acc_mag[vwma_pkg::MAG_W-1:16];
                num_next = {acc_mag[15:0], 1'b0};
                cnt_next = '0;
            end
            vwma_pkg::S_DIV:
            begin
                rem_next = div_ge ? div_sub[vwma_pkg::DEN_W-1:0] : div_t[vwma_pkg::DEN_W-1:0];
                num_next = {num_reg[vwma_pkg::QB_W-2:0], div_ge};
                cnt_next = cnt_reg + 1'b1;
            end
            vwma_pkg::S_FIN:
            begin
                ram_we                   = 1'b1;
                ram_wdata.filled         = 1'b1;
                ram_wdata.weight         = wsum_new;
                ram_wdata.mean           = mean_new;
                result_next.mean_value   = mean_new;
                result_next.weight_total = vwma_pkg::sat_total(wsum_new);
                result_next.has_data     = 1'b1;
                done_next                = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= vwma_pkg::S_INIT;
            clr_cnt_reg <= '0;
            cnt_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            cnt_reg     <= cnt_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        op_reg     <= op_next;
        w_reg      <= w_next;
        v_reg      <= v_next;
        m_reg      <= m_next;
        wsum_reg   <= wsum_next;
        den_reg    <= den_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        neg_reg    <= neg_next;
        rem_reg    <= rem_next;
        num_reg    <= num_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // a result beat always follows an accepted item or the end of its work
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("result beat without an item in flight");

    // an empty voxel never reports a mean or a weight
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.has_data |-> (result.mean_value == '0) && (result.weight_total == '0))
        else $error("empty result carries data");

    // the store is only written by the sequencer, never while idle
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vwma_pkg::S_IDLE) |-> !ram_we)
        else $error("store written while idle");

endmodule

>>> bench/tb.sv
// tb: self-checking bench for voxel_weighted_mean_accumulator, directed beats then random traffic
// depends on vwma_pkg and the accumulator rtl; predicts every result with its own voxel model

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_COUNT = 1100;
    localparam int HOT_COUNT  = 16;
    localparam int MAX_CLEARS = 3;
    localparam int DRAIN_GAP  = 30;

    class voxel_mean_model;
        logic signed [15:0]          mean_q [vwma_pkg::VOXEL_COUNT];
        logic [vwma_pkg::WSUM_W-1:0] wsum_q [vwma_pkg::VOXEL_COUNT];
        bit                          filled_q [vwma_pkg::VOXEL_COUNT];
        vwma_pkg::result_t           results_due [$];
        int                          mismatches;

        function int pending();
            return results_due.size();
        endfunction

        task flag_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        // (W*m + w*v) / (W+w), nearest with ties away from zero, clamped to signed 16 bits
        function int blended_mean(longint unsigned wsum, int m, longint unsigned w, int v);
            longint unsigned am, av, pos, neg, den, mag, q;
            bit negative;
            am  = (m < 0) ? longint'(-m) : longint'(m);
            av  = (v < 0) ? longint'(-v) : longint'(v);
            pos = 0;
            neg = 0;
            if (m < 0) neg += wsum * am; else pos += wsum * am;
            if (v < 0) neg += w * av; else pos += w * av;
            den = wsum + w;
            if (den == 0)
                return m;
            negative = neg > pos;
            mag = negative ? neg - pos : pos - neg;
            q = mag / den;
            if (mag % den >= den - den / 2)
                q++;
            if (negative)
                return (q > 32768) ? -32768 : -int'(q);
            return (q > 32767) ? 32767 : int'(q);
        endfunction

        function void note_cmd(vwma_pkg::cmd_t c);
            vwma_pkg::result_t r;
            int unsigned       idx;
            longint unsigned   s;
            r   = '0;
            idx = 32'(c.voxel_addr);
            case (c.operation)
                vwma_pkg::OP_CLEAR:
                    foreach (filled_q[i]) filled_q[i] = 1'b0;
                vwma_pkg::OP_ACC:
                    if (!filled_q[idx])
                    begin
                        mean_q[idx]   = c.sample_value;
                        wsum_q[idx]   = vwma_pkg::WSUM_W'(c.sample_weight);
                        filled_q[idx] = 1'b1;
                    end
                    else
                    begin
                        mean_q[idx] = 16'(blended_mean(64'(wsum_q[idx]), $signed(mean_q[idx]),
                                                       64'(c.sample_weight),
                                                       $signed(c.sample_value)));
                        s = 64'(wsum_q[idx]) + 64'(c.sample_weight);
                        wsum_q[idx] = (s > 64'(vwma_pkg::WSUM_MAX)) ? vwma_pkg::WSUM_MAX
                                                                    : s[vwma_pkg::WSUM_W-1:0];
                    end
                default: ;
            endcase
            if ((c.operation == vwma_pkg::OP_ACC || c.operation == vwma_pkg::OP_READ)
                && filled_q[idx])
            begin
                r.mean_value   = mean_q[idx];
                r.weight_total = wsum_q[idx];
                r.has_data     = 1'b1;
            end
            results_due = {results_due, r};
        endfunction

        task check_result(vwma_pkg::result_t got);
            vwma_pkg::result_t want;
            if (results_due.size() == 0)
            begin
                flag_mismatch($sformatf("result beat with nothing due: %p", got));
                return;
            end
            want = results_due.pop_front();
            if (got.mean_value !== want.mean_value)
                flag_mismatch($sformatf("mean_value %h, want %h", got.mean_value, want.mean_value));
            if (got.weight_total !== want.weight_total)
                flag_mismatch($sformatf("weight_total %h, want %h",
                                        got.weight_total, want.weight_total));
            if (got.has_data !== want.has_data)
                flag_mismatch($sformatf("has_data %b, want %b", got.has_data, want.has_data));
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              done;
    vwma_pkg::cmd_t    cmd;
    vwma_pkg::result_t result;

    logic [15:0]     hot_voxels [HOT_COUNT];
    voxel_mean_model sb = new();

    voxel_weighted_mean_accumulator i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    function automatic vwma_pkg::cmd_t make_cmd(vwma_pkg::op_t op, logic [15:0] idx,
                                                logic [15:0] w, logic [15:0] v);
        vwma_pkg::cmd_t c;
        c.operation     = op;
        c.voxel_addr    = idx;
        c.sample_weight = w;
        c.sample_value  = v;
        return c;
    endfunction

    function automatic vwma_pkg::cmd_t random_cmd();
        vwma_pkg::cmd_t c;
        int unsigned    pick;
        pick = $urandom_range(0, 99);
        c.operation = (pick < 60) ? vwma_pkg::OP_ACC
                    : (pick < 95) ? vwma_pkg::OP_READ : vwma_pkg::OP_NOP;
        // mostly a small pool so accumulates land on filled voxels
        c.voxel_addr = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : hot_voxels[$urandom_range(0, HOT_COUNT - 1)];
        case ($urandom_range(0, 7))
            0:       c.sample_weight = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
            1:       c.sample_weight = ($urandom_range(0, 1) == 0) ? 16'h0001 : 16'h8000;
            2, 3:    c.sample_weight = 16'($urandom_range(1, 255));
            default: c.sample_weight = 16'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       c.sample_value = 16'h8000;
            1:       c.sample_value = 16'h7FFF;
            2:       c.sample_value = 16'($urandom_range(0, 7)) - 16'd4;
            default: c.sample_value = 16'($urandom);
        endcase
        return c;
    endfunction

    // holds start until the block takes the beat
    task automatic send(vwma_pkg::cmd_t c);
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_cmd(c);
    endtask

    task automatic pause(int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    initial
    begin
        vwma_pkg::cmd_t c;
        int             burst_left;
        int             clears;
        start <= 1'b0;
        cmd   <= '0;
        rst_n <= 1'b0;
        foreach (hot_voxels[i]) hot_voxels[i] = 16'($urandom);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty voxel, extremes of value and weight, index extremes
        send(make_cmd(vwma_pkg::OP_READ, 16'h0000, 16'h0001, 16'h0000));
        send(make_cmd(vwma_pkg::OP_ACC, 16'h0000, 16'h8000, 16'h7FFF));
        send(make_cmd(vwma_pkg::OP_ACC, 16'h0000, 16'hFFFF, 16'h8000));
        send(make_cmd(vwma_pkg::OP_READ, 16'h0000, 16'h0000, 16'h0000));
        send(make_cmd(vwma_pkg::OP_ACC, 16'hFFFF, 16'h0001, 16'h8000));
        send(make_cmd(vwma_pkg::OP_ACC, 16'hFFFF, 16'h0001, 16'h7FFF));
        send(make_cmd(vwma_pkg::OP_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        // zero weight: first hit keeps sum zero, then zero denominator keeps the mean
        send(make_cmd(vwma_pkg::OP_ACC, 16'h1234, 16'h0000, 16'h0100));
        send(make_cmd(vwma_pkg::OP_ACC, 16'h1234, 16'h0000, 16'h5555));
        send(make_cmd(vwma_pkg::OP_ACC, 16'h1234, 16'h0001, 16'hFFFF));
        // half-way ties round away from zero, both signs
        send(make_cmd(vwma_pkg::OP_ACC, 16'h0005, 16'h0001, 16'h0000));
        send(make_cmd(vwma_pkg::OP_ACC, 16'h0005, 16'h0001, 16'h0001));
        send(make_cmd(vwma_pkg::OP_ACC, 16'h0006, 16'h0001, 16'h0000));
        send(make_cmd(vwma_pkg::OP_ACC, 16'h0006, 16'h0001, 16'hFFFF));
        // unused code reports zeros even on a filled voxel
        send(make_cmd(vwma_pkg::OP_NOP, 16'h0000, 16'hFFFF, 16'hFFFF));
        send(make_cmd(vwma_pkg::OP_NOP, 16'hAAAA, 16'h5555, 16'hAAAA));
        pause(7);
        send(make_cmd(vwma_pkg::OP_CLEAR, 16'h5555, 16'hAAAA, 16'h5555));
        send(make_cmd(vwma_pkg::OP_READ, 16'h0000, 16'h0000, 16'h0000));
        send(make_cmd(vwma_pkg::OP_READ, 16'hFFFF, 16'h0000, 16'h0000));
        send(make_cmd(vwma_pkg::OP_ACC, 16'h0000, 16'h0002, 16'h0123));
        send(make_cmd(vwma_pkg::OP_ACC, 16'h0000, 16'h0003, 16'hFEDC));
        send(make_cmd(vwma_pkg::OP_READ, 16'h0000, 16'h0000, 16'h0000));

        burst_left = 0;
        clears     = 0;
        for (int n = 0; n < ITEM_COUNT; n++)
        begin
            if (n == ITEM_COUNT / 2)
                drain();
            if (burst_left == 0)
            begin
                pause(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30));
                burst_left = $urandom_range(1, 40);
            end
            if (clears < MAX_CLEARS && $urandom_range(0, 349) == 0)
            begin
                c = make_cmd(vwma_pkg::OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
                clears++;
            end
            else
                c = random_cmd();
            send(c);
            burst_left--;
        end

        drain();
        repeat (DRAIN_GAP) @(posedge clk);
        if (sb.pending() != 0)
            sb.flag_mismatch("results still due after the last beat");
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // reset sweep and each clear cost a full pass over the voxels
    initial
    begin
        #10ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
